>>> src/upd_pkg.sv
// Shared types, character constants and hex helpers for the percent decoder.
package upd_pkg;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2
  } phase_e;

  // Bytes one input item yields, in emit order; cnt of zero means none.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] chars;
    logic            last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c >= 8'h30 && c <= 8'h39) || (lc >= 8'h61 && lc <= 8'h66);
  endfunction

  // Digits keep their low nibble, letters add nine.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c[6]) begin
      return c[3:0] + 4'd9;
    end
    return c[3:0];
  endfunction

endpackage

>>> src/upd_front.sv
// Front end: accepts input items, tracks escape phase, emits byte commands.
module upd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    in_char_i,
  input  logic          in_end_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          full_i,
  output logic          push_o,
  output upd_pkg::cmd_t cmd_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      first_q, first_d;
  logic            accept;
  logic            hex;
  logic            opens;
  logic            f_emit;
  logic [7:0]      f_byte;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign hex        = upd_pkg::is_hex(in_char_i);
  // A '%' that is not the final byte opens an escape instead of emitting.
  assign opens      = (in_char_i == upd_pkg::CharPercent) && !in_end_i;
  assign f_emit     = !opens;
  assign f_byte     = (in_char_i == upd_pkg::CharPlus) ? upd_pkg::CharSpace : in_char_i;

  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    if (accept) begin
      unique case (phase_q)
        upd_pkg::PH_PCT: begin
          if (hex && !in_end_i) begin
            phase_d = upd_pkg::PH_HEX;
            first_d = in_char_i;
          end else if (!hex && opens) begin
            phase_d = upd_pkg::PH_PCT;
          end else begin
            phase_d = upd_pkg::PH_IDLE;
          end
        end
        upd_pkg::PH_HEX: begin
          phase_d = (!hex && opens) ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        end
        default: begin
          phase_d = opens ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.last  = in_end_i;
    cmd_o.chars = '0;
    cmd_o.cnt   = 2'd0;
    unique case (phase_q)
      upd_pkg::PH_PCT: begin
        cmd_o.chars[0] = upd_pkg::CharPercent;
        if (hex) begin
          cmd_o.chars[1] = in_char_i;
          cmd_o.cnt      = in_end_i ? 2'd2 : 2'd0;
        end else begin
          cmd_o.chars[1] = f_byte;
          cmd_o.cnt      = f_emit ? 2'd2 : 2'd1;
        end
      end
      upd_pkg::PH_HEX: begin
        if (hex) begin
          cmd_o.chars[0] = {upd_pkg::hex_val(first_q), upd_pkg::hex_val(in_char_i)};
          cmd_o.cnt      = 2'd1;
        end else begin
          cmd_o.chars[0] = upd_pkg::CharPercent;
          cmd_o.chars[1] = first_q;
          cmd_o.chars[2] = f_byte;
          cmd_o.cnt      = f_emit ? 2'd3 : 2'd2;
        end
      end
      default: begin
        cmd_o.chars[0] = f_byte;
        cmd_o.cnt      = f_emit ? 2'd1 : 2'd0;
      end
    endcase
  end

  assign push_o = accept && (cmd_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
  end

endmodule

>>> src/upd_fifo.sv
// Small command queue between the front end and the output stage.
module upd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upd_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output upd_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  upd_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

>>> src/upd_back.sv
// Output stage: walks the head command one byte per cycle into the output register while the receiver takes bytes.
module upd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  upd_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic [7:0]    out_char_o,
  output logic          out_end_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  logic [1:0] sel_q, sel_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       end_q, end_d;
  logic       load;
  logic       last_byte;

  assign load      = !empty_i && (!valid_q || out_ready_i);
  assign last_byte = (sel_q == head_i.cnt - 2'd1);
  assign pop_o     = load && last_byte;

  always_comb begin
    sel_d   = sel_q;
    valid_d = valid_q;
    char_d  = char_q;
    end_d   = end_q;
    if (load) begin
      valid_d = 1'b1;
      char_d  = head_i.chars[sel_q];
      end_d   = head_i.last && last_byte;
      sel_d   = last_byte ? 2'd0 : sel_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    end_q  <= end_d;
  end

  assign out_char_o  = char_q;
  assign out_end_o   = end_q;
  assign out_valid_o = valid_q;

endmodule

>>> src/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Input channel: one encoded byte per item (in_char_i), in_end_i on the final
// byte of a string. Output channel: decoded bytes, out_end_o on the final
// decoded byte of the string. Both channels use valid/ready.
// '%' with two hex digits becomes one byte, '+' becomes a space, other bytes
// pass through; a broken or truncated escape goes out as literal bytes.
// The front end decodes one item per cycle (while the queue has room) into a
// command of zero to three bytes and writes it to a FifoDepth-entry queue;
// the output stage drains one byte per cycle into a registered output while
// the receiver is ready. The first result of an item passes through the queue
// and then the output register. Throughput: one input item per cycle while
// each yields at most one byte and the receiver is ready; an item that yields
// two or three bytes holds the output stage until all of its bytes are out,
// and the queue fills behind it.
// A stalled receiver holds the output register; input ready drops only when
// the queue is full. Reset clears the escape phase, the queue and the output
// valid; the first item may be offered in the cycle after reset is released.
module url_percent_decoder #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_char_i,
  input  logic       in_end_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_char_o,
  output logic       out_end_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  upd_pkg::cmd_t cmd, head;
  logic          push, pop, full, empty;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_char_i  (in_char_i),
    .in_end_i   (in_end_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  upd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_char_o  (out_char_o),
    .out_end_o   (out_end_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

>>> test/tb_url_percent_decoder.sv
// Self-checking testbench for the streaming URL percent decoder.
module tb_url_percent_decoder;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpF  = 8'h46;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowF = 8'h66;
  localparam int unsigned RandItems = 260;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } enc_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } dec_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] in_char_i = '0;
  logic       in_end_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] out_char_o;
  logic       out_end_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  enc_item_t pending[$];
  dec_byte_t expected_bytes[$];
  int unsigned mismatches = 0;
  int unsigned bytes_seen = 0;
  bit drain_next = 1'b0;

  // Decoder state as predicted from the accepted items.
  upd_pkg::phase_e esc_phase = upd_pkg::PH_IDLE;
  logic [7:0]      held_hex = '0;

  url_percent_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_char_i  (in_char_i),
    .in_end_i   (in_end_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_char_o (out_char_o),
    .out_end_o  (out_end_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit hex_digit(input logic [7:0] c);
    return (c >= CharZero && c <= CharNine) || (c >= CharUpA && c <= CharUpF) ||
           (c >= CharLowA && c <= CharLowF);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CharNine) begin
      v = c - CharZero;
    end else if (c <= CharUpF) begin
      v = c - CharUpA + 8'd10;
    end else begin
      v = c - CharLowA + 8'd10;
    end
    return v[3:0];
  endfunction

  // Decode a byte with no escape open; may open a new one.
  function automatic void decode_plain(input logic [7:0] c, input logic last,
                                       ref logic [7:0] outs[$]);
    if (c == upd_pkg::CharPercent) begin
      if (last) begin
        outs.push_back(upd_pkg::CharPercent);
      end else begin
        esc_phase = upd_pkg::PH_PCT;
      end
    end else if (c == upd_pkg::CharPlus) begin
      outs.push_back(upd_pkg::CharSpace);
    end else begin
      outs.push_back(c);
    end
  endfunction

  function automatic void predict_decoded(input logic [7:0] c, input logic last);
    logic [7:0]      outs[$];
    upd_pkg::phase_e prev;
    prev = esc_phase;
    esc_phase = upd_pkg::PH_IDLE;
    case (prev)
      upd_pkg::PH_PCT: begin
        if (hex_digit(c) && !last) begin
          esc_phase = upd_pkg::PH_HEX;
          held_hex = c;
        end else if (hex_digit(c)) begin
          outs.push_back(upd_pkg::CharPercent);
          outs.push_back(c);
        end else begin
          outs.push_back(upd_pkg::CharPercent);
          decode_plain(c, last, outs);
        end
      end
      upd_pkg::PH_HEX: begin
        if (hex_digit(c)) begin
          outs.push_back({nibble_of(held_hex), nibble_of(c)});
        end else begin
          outs.push_back(upd_pkg::CharPercent);
          outs.push_back(held_hex);
          decode_plain(c, last, outs);
        end
      end
      default: decode_plain(c, last, outs);
    endcase
    foreach (outs[i]) begin
      expected_bytes.push_back('{outs[i], last && (i == outs.size() - 1)});
    end
    if (last) begin
      esc_phase = upd_pkg::PH_IDLE;
      held_hex = '0;
    end
  endfunction

  function automatic void add_item(input logic [7:0] c, input logic last);
    pending.push_back('{c, last, drain_next});
    drain_next = 1'b0;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_item(s[i], i == s.len() - 1);
    end
  endfunction

  function automatic logic [7:0] rand_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_digit(c)) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Well-formed escapes with random content (the largest share), plus signs, some broken ones and noise.
  function automatic int unsigned add_random_string();
    logic [7:0] text[$];
    int unsigned pieces;
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          text.push_back(upd_pkg::CharPercent);
          text.push_back(rand_hex());
          text.push_back(rand_hex());
        end
        8, 9, 10: text.push_back(upd_pkg::CharPlus);
        11: begin
          text.push_back(upd_pkg::CharPercent);
          text.push_back(rand_non_hex());
        end
        12: begin
          text.push_back(upd_pkg::CharPercent);
          text.push_back(rand_hex());
          text.push_back(rand_non_hex());
        end
        13: text.push_back(upd_pkg::CharPercent);
        14: begin
          text.push_back(upd_pkg::CharPercent);
          text.push_back(rand_hex());
        end
        default: text.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    foreach (text[i]) begin
      add_item(text[i], i == text.size() - 1);
    end
    return text.size();
  endfunction

  // Sender: bursts of random length with random gaps.
  always @(posedge clk_i) begin : drive_proc
    enc_item_t nxt;
    int unsigned burst_left;
    int unsigned gap_left;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_decoded(in_char_i, in_end_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending[0].drain && expected_bytes.size() != 0) begin
          // hold back until every decoded byte so far has come out
          in_valid_i <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          in_char_i  <= nxt.ch;
          in_end_i   <= nxt.last;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: stall pattern of its own, with two long hold-offs.
  always @(posedge clk_i) begin : accept_proc
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned mode_left;
    int unsigned stall_mode;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if ((holds_done == 0 && bytes_seen >= 40) ||
                   (holds_done == 1 && bytes_seen >= 180)) begin
        hold_left = HoldCycles;
        holds_done++;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 9) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    dec_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected byte: char %h end %b", out_char_o, out_end_o);
        end
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_char_o !== want.ch || out_end_o !== want.last) begin
          if (mismatches < 10) begin
            $display("mismatch at byte %0d: char %h end %b, want char %h end %b",
                     bytes_seen, out_char_o, out_end_o, want.ch, want.last);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stim_proc
    int unsigned rand_items;
    int unsigned next_drain;
    // escapes in both cases and plus
    add_text("%4a");
    add_text("%Ff+");
    add_text("%00");
    // truncated escapes at end of string
    add_text("%0");
    add_text("%");
    add_text("%%");
    // escape broken by non-hex; the breaking byte is decoded as plain
    add_text("%4g");
    add_text("%9%");
    add_text("%G");
    add_text("%+");
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b1);
    drain_next = 1'b1;
    rand_items = 0;
    next_drain = 90;
    while (rand_items < RandItems) begin
      if (rand_items >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 90;
      end
      rand_items += add_random_string();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending.size() != 0 || in_valid_i || expected_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
